[rtl/wscc_pkg.sv]
`default_nettype none
package wscc_pkg;
  // ring depth, a power of two so slot indexes wrap on their own bits
  localparam int WINDOW_DEPTH = 32;

  localparam logic [1:0] CFG_SEG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_FILE_LEN  = 2'd1;
  localparam logic [1:0] CFG_INIT_THR  = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

  localparam logic [1:0] KIND_NEW     = 2'd0;
  localparam logic [1:0] KIND_RETX    = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_REFUSED = 2'd3;

  // classified request handed from front to back
  typedef enum logic [1:0] {
    CMD_ACK  = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DONE = 2'd2,
    CMD_REF  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] ack_number;
    logic [31:0] peer_seq;
    logic [15:0] peer_window;
    logic [31:0] peer_byte_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [31:0] byte_offset;
    logic [15:0] seg_length;
    logic        seg_fin;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

[rtl/window_sender_congestion_control.sv]
// window sender with reno congestion control
// in_ channel carries acknowledgments (tuser 0) and time ticks (tuser 1)
// out_ channel carries segment descriptors, tuser holds the kind,
// last marks the final one per request
// cfg_ port writes segment size, file length, initial threshold, timeout
// an acknowledgment retires the acknowledged entries from the ring one by one,
// then emits new descriptors up to the window limit; a timeout resends every
// entry in the ring
// ring reads go through one registered memory port
// a two-entry queue lets new requests be taken while the back end works
// reset clears window state, empties the ring and loads register defaults
// when the receiver stalls, the back end holds its result and pauses
`default_nettype none
module window_sender_congestion_control
  import wscc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // ack_number, peer_seq, peer_fin, peer_window, peer_byte_count, pad
  input  wire logic [119:0] in_tdata,
  // opcode
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // seg_seq, seg_ack, byte_offset, seg_length, seg_fin, pad
  output logic [119:0]      out_tdata,
  // kind
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);
  logic q_valid, q_ready, rv;
  req_t qd;
  res_t rd;

  wscc_front #(.QDEPTH(2)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .opcode(in_tuser), .ack_number(in_tdata[31:0]), .peer_seq(in_tdata[63:32]),
    .peer_fin(in_tdata[64]), .peer_window(in_tdata[80:65]),
    .peer_byte_count(in_tdata[112:81]),
    .q_valid, .q_ready, .q_data(qd)
  );

  wscc_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .q_valid, .q_ready, .q_data(qd),
    .res_valid(rv), .res_ready(out_tready), .res_data(rd)
  );

  assign out_tvalid = rv;
  assign out_tlast  = rd.last;
  assign out_tuser  = rd.kind;
  assign out_tdata  = {7'd0, rd.seg_fin, rd.seg_length, rd.byte_offset,
                       rd.seg_ack, rd.seg_seq};
endmodule
`default_nettype wire

[rtl/wscc_front.sv]
`default_nettype none
module wscc_front
  import wscc_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       opcode,
  input  wire logic [31:0] ack_number,
  input  wire logic [31:0] peer_seq,
  input  wire logic       peer_fin,
  input  wire logic [15:0] peer_window,
  input  wire logic [31:0] peer_byte_count,
  output logic            q_valid,
  input  wire logic       q_ready,
  output req_t            q_data
);
  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  req_t            mem_r [QDEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  req_t            req;
  logic            push, pop;

  always_comb begin
    req.ack_number      = ack_number;
    req.peer_seq        = peer_seq;
    req.peer_window     = peer_window;
    req.peer_byte_count = peer_byte_count;
    if (opcode)                        req.cmd = CMD_TICK;
    else if (peer_fin && &peer_seq)    req.cmd = CMD_REF;
    else if (peer_fin)                 req.cmd = CMD_DONE;
    else                               req.cmd = CMD_ACK;
  end

  assign in_ready = (cnt_r != QDEPTH[AW:0]);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

[rtl/wscc_back.sv]
`default_nettype none
module wscc_back
  import wscc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  req_t             q_data,
  output logic             res_valid,
  input  wire logic        res_ready,
  output res_t             res_data
);
  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int CW = PW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RETIRE, S_SETUP, S_EMIT, S_RETX, S_RD, S_OUT
  } state_t;

  state_t state_r, ret_r;
  logic [15:0] seg_size_r;
  logic [31:0] file_len_r, timeout_r;
  logic [15:0] cwnd_r, ssthr_r;
  logic [1:0]  dup_r;
  logic [PW-1:0] head_r;
  logic [CW-1:0] count_r, k_r;
  logic [31:0] idle_r;
  logic        fin_r;
  req_t        req_r;
  logic [31:0] ackv_r;            // ack applied to all remaining entries
  logic [15:0] limit_r;
  logic [15:0] limit_nxt;
  logic [31:0] off_r, sq_r, ak_r;
  logic        started_r;

  // ring stores; every live entry shares the ack held in ackv_r
  logic [31:0] rseq [WINDOW_DEPTH];
  logic [31:0] rend [WINDOW_DEPTH];
  logic [15:0] rlen [WINDOW_DEPTH];
  logic        rfin [WINDOW_DEPTH];
  logic [31:0] rd_seq_r, rd_end_r;
  logic [15:0] rd_len_r;
  logic        rd_fin_r;
  logic [PW-1:0] rd_addr;
  logic        we;
  logic [PW-1:0] wa;
  logic [31:0] w_seq, w_end;
  logic [15:0] w_len;
  logic        w_fin;

  // head seq kept in a register to avoid a ring read
  logic [31:0] head_seq_r;

  res_t        out_r;
  logic        out_v_r;

  logic [31:0] rem, len32, nend;
  logic [15:0] len;
  logic        sfin;
  logic [16:0] grow;

  always_comb begin
    rem   = file_len_r - off_r;
    len32 = (off_r < file_len_r) ? ((32'(seg_size_r) < rem) ? 32'(seg_size_r) : rem) : '0;
    len   = len32[15:0];
    nend  = off_r + len32;
    sfin  = (nend >= file_len_r);
    grow  = (cwnd_r <= ssthr_r) ? {cwnd_r, 1'b0} : 17'(cwnd_r) + 17'd1;
    limit_nxt = (cwnd_r < req_r.peer_window) ? cwnd_r : req_r.peer_window;
    if (16'(WINDOW_DEPTH) < limit_nxt) limit_nxt = 16'(WINDOW_DEPTH);
  end

  assign rd_addr   = PW'(head_r + k_r[PW-1:0]);
  assign res_valid = out_v_r;
  assign res_data  = out_r;
  assign q_ready   = (state_r == S_IDLE) && !out_v_r;

  always_ff @(posedge clk) begin
    if (we) begin
      rseq[wa] <= w_seq; rend[wa] <= w_end; rlen[wa] <= w_len; rfin[wa] <= w_fin;
    end
    rd_seq_r <= rseq[rd_addr]; rd_end_r <= rend[rd_addr];
    rd_len_r <= rlen[rd_addr]; rd_fin_r <= rfin[rd_addr];
  end

  always_comb begin
    we    = (state_r == S_EMIT) && !out_v_r && (k_r < CW'(limit_r)) && !started_r;
    wa    = PW'(head_r + count_r[PW-1:0]);
    w_seq = sq_r; w_end = nend; w_len = len; w_fin = sfin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ret_r <= S_IDLE;
      seg_size_r <= 16'd1024; file_len_r <= '0;
      timeout_r <= 32'd5000; cwnd_r <= 16'd1; ssthr_r <= 16'd32; dup_r <= '0;
      head_r <= '0; count_r <= '0; idle_r <= '0; fin_r <= 1'b0; out_v_r <= 1'b0;
      k_r <= '0; started_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SEG_SIZE: seg_size_r <= cfg_data[15:0];
          CFG_FILE_LEN: file_len_r <= cfg_data;
          CFG_INIT_THR: ssthr_r <= cfg_data[15:0];
          CFG_TIMEOUT:  timeout_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_v_r && res_ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_valid && !out_v_r) begin
          req_r <= q_data;
          if (fin_r) begin
            // ignore
          end else if (q_data.cmd == CMD_REF || q_data.cmd == CMD_DONE) begin
            fin_r <= 1'b1;
            out_r <= '{kind: (q_data.cmd == CMD_REF) ? KIND_REFUSED : KIND_DONE,
                       seg_seq: '0, seg_ack: '0, byte_offset: '0, seg_length: '0,
                       seg_fin: 1'b0, last: 1'b1};
            out_v_r <= 1'b1;
          end else if (q_data.cmd == CMD_TICK) begin
            if (((idle_r == '1) ? idle_r : idle_r + 1) >= timeout_r) begin
              ssthr_r <= cwnd_r >> 1; cwnd_r <= 16'd1; idle_r <= '0;
              k_r <= '0;
              if (count_r != '0) state_r <= S_RD;
              ret_r <= S_RETX;
            end else if (idle_r != '1) idle_r <= idle_r + 1;
          end else begin
            if (count_r != '0 && head_seq_r <= q_data.ack_number) begin
              cwnd_r <= grow[16] ? 16'hFFFF : grow[15:0]; dup_r <= '0;
            end else if (dup_r != 2'd3) begin
              dup_r <= dup_r + 1'b1;
              if (dup_r == 2'd2) begin
                ssthr_r <= cwnd_r >> 1; cwnd_r <= (cwnd_r >> 1) + 16'd3;
              end
            end
            ackv_r <= q_data.peer_seq + 32'd1;
            state_r <= S_RETIRE;
          end
        end
        S_RETIRE: begin
          if (count_r != '0 && head_seq_r < req_r.ack_number) begin
            // head_r already points at the new head during the read
            head_r <= PW'(head_r + 1'b1); count_r <= count_r - 1'b1; idle_r <= '0;
            k_r <= '0; ret_r <= S_RETIRE; state_r <= S_RD;
          end else begin
            limit_r <= limit_nxt;
            k_r <= count_r - 1'b1; ret_r <= S_SETUP;
            state_r <= (count_r != '0) ? S_RD : S_SETUP;
          end
        end
        S_SETUP: begin
          if (count_r != '0) begin
            off_r <= rd_end_r; sq_r <= rd_seq_r + 1; ak_r <= ackv_r;
            started_r <= rd_fin_r;
          end else begin
            off_r <= req_r.peer_byte_count; sq_r <= req_r.ack_number; ak_r <= ackv_r;
            started_r <= 1'b0;
          end
          k_r <= count_r; state_r <= S_EMIT;
        end
        S_EMIT: if (!out_v_r) begin
          if (started_r || k_r >= CW'(limit_r)) begin
            state_r <= S_IDLE;
          end else begin
            if (count_r == '0) begin idle_r <= '0; head_seq_r <= sq_r; end
            count_r <= count_r + 1'b1; k_r <= k_r + 1'b1;
            out_r <= '{kind: KIND_NEW, seg_seq: sq_r, seg_ack: ak_r, byte_offset: off_r,
                       seg_length: len, seg_fin: sfin,
                       last: sfin || (k_r + 1'b1 >= CW'(limit_r))};
            out_v_r <= 1'b1;
            off_r <= nend; sq_r <= sq_r + 1; started_r <= sfin;
          end
        end
        S_RD: state_r <= S_OUT;
        S_OUT: begin
          if (ret_r == S_RETIRE) begin
            head_seq_r <= rd_seq_r; state_r <= S_RETIRE;
          end else if (ret_r == S_SETUP) begin
            state_r <= S_SETUP;
          end else state_r <= S_RETX;
        end
        S_RETX: if (!out_v_r) begin
          out_r <= '{kind: KIND_RETX, seg_seq: rd_seq_r, seg_ack: ackv_r,
                     byte_offset: rd_end_r - 32'(rd_len_r), seg_length: rd_len_r,
                     seg_fin: rd_fin_r, last: (k_r + 1'b1 == count_r)};
          out_v_r <= 1'b1;
          k_r <= k_r + 1'b1;
          state_r <= (k_r + 1'b1 == count_r) ? S_IDLE : S_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(WINDOW_DEPTH))
    else $error("ring overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cwnd_r != '0)
    else $error("zero window");
  assert property (@(posedge clk) disable iff (!rst_n) out_v_r && !res_ready |=> out_v_r)
    else $error("result dropped");
endmodule
`default_nettype wire
